// ----- hdl/wsld_pkg.sv -----
package wsld_pkg;

	localparam int WINDOW_DEPTH_DEF = 16;
	localparam int VAR_W            = 32;
	localparam int AXES             = 3;
	localparam int COUNT_W          = 5;
	localparam int COUNT_MAX        = 31;
	localparam int PADDR_W          = 3;
	localparam logic [VAR_W-1:0] THRESHOLD_RESET = 32'd16777;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_CLEAR  = 1'b1;

	localparam logic REG_THRESHOLD = 1'b0;

	typedef struct packed {
		logic             operation;
		logic [VAR_W-1:0] var_x;
		logic [VAR_W-1:0] var_y;
		logic [VAR_W-1:0] var_z;
		logic             positioning_ok;
		logic             calibrated;
	} sample_t;

	typedef struct packed {
		logic               locked;
		logic [COUNT_W-1:0] filled_count;
	} result_t;

	typedef struct packed {
		logic                       valid;
		logic [AXES-1:0][VAR_W-1:0] v;
	} entry_t;

	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctl_t;

	typedef struct packed {
		logic start;
		logic step;
	} span_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

endpackage

// ----- hdl/wsld_cell.sv -----
module wsld_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  wsld_pkg::cell_ctl_t ctl,
	input  wsld_pkg::entry_t    d,
	output wsld_pkg::entry_t    q
);
	import wsld_pkg::*;

	logic                       valid_q;
	logic [AXES-1:0][VAR_W-1:0] v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
		end else if (ctl.shift) begin
			valid_q <= d.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift && !ctl.clear) begin
			v_q <= d.v;
		end
	end

	assign q.valid = valid_q;
	assign q.v     = v_q;

endmodule

// ----- hdl/wsld_span.sv -----
module wsld_span #(
	parameter int WINDOW_DEPTH = wsld_pkg::WINDOW_DEPTH_DEF
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  wsld_pkg::span_ctl_t                             ctl,
	input  wsld_pkg::entry_t                                tail,
	output logic [wsld_pkg::AXES-1:0][wsld_pkg::VAR_W-1:0]  hi,
	output logic [wsld_pkg::AXES-1:0][wsld_pkg::VAR_W-1:0]  lo,
	output logic [$clog2(WINDOW_DEPTH+1)-1:0]               count
);
	import wsld_pkg::*;

	localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);

	logic [AXES-1:0][VAR_W-1:0] hi_q;
	logic [AXES-1:0][VAR_W-1:0] lo_q;
	logic [FILL_W-1:0]          count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.start) begin
			count_q <= '0;
		end else if (ctl.step && tail.valid) begin
			count_q <= count_q + FILL_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			hi_q <= '0;
			lo_q <= '1;
		end else if (ctl.step && tail.valid) begin
			for (int a = 0; a < AXES; a++) begin
				if (tail.v[a] > hi_q[a]) begin
					hi_q[a] <= tail.v[a];
				end
				if (tail.v[a] < lo_q[a]) begin
					lo_q[a] <= tail.v[a];
				end
			end
		end
	end

	assign hi    = hi_q;
	assign lo    = lo_q;
	assign count = count_q;

endmodule

// ----- hdl/window_spread_lock_detector_top.sv -----
// Sample transfers are taken one at a time. A sample shifts into the head of a
// chain of WINDOW_DEPTH cells, the oldest entry drops off the tail, and the
// chain then rotates once around, so the tail cell feeds the min/max/count unit
// with each entry in turn. The result is loaded once the rotation ends and the
// result register is free; no new sample is taken before then, and the rotation
// through the cell chain sets the pace when the result side keeps up.
// A clear transfer empties the window and yields locked = 0, filled_count = 0.
// The result register holds one result, so the next sample is taken while it
// waits. spread_threshold sits at byte address 0 of the APB port.
module window_spread_lock_detector_top #(
	parameter int WINDOW_DEPTH = wsld_pkg::WINDOW_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sample_valid,
	output logic                          sample_ready,
	input  wsld_pkg::sample_t             sample,
	output logic                          result_valid,
	input  logic                          result_ready,
	output wsld_pkg::result_t             result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [wsld_pkg::PADDR_W-1:0]  paddr,
	input  logic [wsld_pkg::VAR_W-1:0]    pwdata,
	output logic [wsld_pkg::VAR_W-1:0]    prdata,
	output logic                          pready
);
	import wsld_pkg::*;

	localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
	localparam int CNT_W  = $clog2(WINDOW_DEPTH);
	localparam logic [CNT_W-1:0]  SCAN_LAST = CNT_W'(WINDOW_DEPTH - 1);
	localparam logic [FILL_W-1:0] FULL      = FILL_W'(WINDOW_DEPTH);

	state_t                     state_q;
	state_t                     state_d;
	logic [CNT_W-1:0]           scan_q;
	logic                       flags_q;
	logic [VAR_W-1:0]           threshold_q;
	logic                       result_valid_q;
	result_t                    result_q;
	logic                       take;
	logic                       load;
	logic                       cfg_write;
	cell_ctl_t                  cell_ctl;
	span_ctl_t                  span_ctl;
	entry_t                     head;
	entry_t                     chain [WINDOW_DEPTH];
	logic [AXES-1:0][VAR_W-1:0] hi;
	logic [AXES-1:0][VAR_W-1:0] lo;
	logic [FILL_W-1:0]          count;
	logic                       stable;

	assign cfg_write = psel && penable && pwrite;
	assign pready    = 1'b1;
	assign prdata    = (paddr[PADDR_W-1] == REG_THRESHOLD) ? threshold_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
		end else if (cfg_write && paddr[PADDR_W-1] == REG_THRESHOLD) begin
			threshold_q <= pwdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		sample_ready = 1'b0;
		load         = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				sample_ready = 1'b1;
				if (sample_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_q == SCAN_LAST) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!result_valid_q || result_ready) begin
					load    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign take = sample_valid && sample_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
		end else if (take) begin
			scan_q <= '0;
		end else if (state_q == ST_SCAN) begin
			scan_q <= scan_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			flags_q <= sample.positioning_ok && sample.calibrated;
		end
	end

	assign cell_ctl.clear = take && sample.operation == OP_CLEAR;
	assign cell_ctl.shift = (take && sample.operation == OP_SAMPLE) || state_q == ST_SCAN;
	assign span_ctl.start = take;
	assign span_ctl.step  = state_q == ST_SCAN;

	always_comb begin
		if (state_q == ST_IDLE) begin
			head.valid = 1'b1;
			head.v[0]  = sample.var_x;
			head.v[1]  = sample.var_y;
			head.v[2]  = sample.var_z;
		end else begin
			head = chain[WINDOW_DEPTH-1];
		end
	end

	for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
		wsld_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (cell_ctl),
			.d      ((i == 0) ? head : chain[(i == 0) ? 0 : i - 1]),
			.q      (chain[i])
		);
	end

	wsld_span #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_span (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (span_ctl),
		.tail   (chain[WINDOW_DEPTH-1]),
		.hi     (hi),
		.lo     (lo),
		.count  (count)
	);

	always_comb begin
		stable = 1'b1;
		for (int a = 0; a < AXES; a++) begin
			if ((hi[a] - lo[a]) >= threshold_q) begin
				stable = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q.locked       <= (count == FULL) && stable && flags_q;
			result_q.filled_count <= (32'(count) > 32'(COUNT_MAX)) ?
				COUNT_W'(COUNT_MAX) : COUNT_W'(count);
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ----- hdl/wsld_chk.sv -----
module wsld_chk #(
	parameter int WINDOW_DEPTH = wsld_pkg::WINDOW_DEPTH_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          sample_valid,
	input logic                          sample_ready,
	input logic                          result_valid,
	input logic                          result_ready,
	input wsld_pkg::result_t             result
);
	import wsld_pkg::*;

	localparam int FULL_SAT = (WINDOW_DEPTH > COUNT_MAX) ? COUNT_MAX : WINDOW_DEPTH;

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready |=> !sample_ready)
		else $error("sample taken while a transfer is in work");

	a_lock_full: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.locked |-> 32'(result.filled_count) == 32'(FULL_SAT))
		else $error("lock reported on a window that is not full");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> 32'(result.filled_count) <= 32'(FULL_SAT))
		else $error("filled count beyond window depth");

endmodule

bind window_spread_lock_detector_top wsld_chk #(
	.WINDOW_DEPTH (WINDOW_DEPTH)
) u_wsld_chk (.*);
